[rtl/are_pkg.sv]
// Shared types, constants and codes of the adaptive range encoder.
`timescale 1ns / 1ps
`default_nettype none
package are_pkg;

    localparam int CF_W            = 15;
    localparam int LOW_W           = 32;
    localparam int DIV_STEPS       = 32;
    localparam int DEF_MAX_SYMBOLS = 256;
    localparam int DEF_NUM_SYMBOLS = 256;
    localparam int NSYM_W          = 9;
    localparam int CAP_W           = 31;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CF_W-1:0]  RESCALE_LIMIT = 15'h3FFF;
    localparam logic [LOW_W-1:0] RANGE_FLOOR   = 32'h0080_0000;
    localparam logic [LOW_W-1:0] RANGE_FULL    = 32'hFFFF_FFFF;
    localparam logic [LOW_W-1:0] POS_MAX       = 32'hFFFF_FFFF;
    localparam logic [CAP_W-1:0] DEF_CAPACITY  = 31'h7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 2'd1;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SYMBOL = 2'd1,
        OP_RAW    = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIV,
        ST_MUL_LOW,
        ST_MUL_RANGE,
        ST_RENORM,
        ST_STATUS,
        ST_BUMP,
        ST_HALVE,
        ST_RAW,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [LOW_W-1:0] dividend;
        logic [CF_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LOW_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/are_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module are_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire are_pkg::div_req_t req,
    output are_pkg::div_rsp_t     rsp
);
    import are_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LOW_W-1:0] quo_reg, quo_next;
    logic [CF_W-1:0]  rem_reg, rem_next;
    logic [CF_W-1:0]  dvs_reg, dvs_next;

    logic [CF_W:0]    rem_sh;
    logic [CF_W+1:0]  diff;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[LOW_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dvs_reg};
        ge        = ~diff[CF_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[CF_W-1:0] : rem_sh[CF_W-1:0];
            quo_next = {quo_reg[LOW_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/adaptive_range_encoder.sv]
// Top level of the adaptive range encoder: control, frequency table and output stage.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: op; tdata: symbol, raw_value, raw_count
// m_*       out  m_tvalid/m_tready  tdata: out_byte .. bad_symbol; tlast: last
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One request at a time. A symbol takes two table reads, a divide, two
// multiplies and renormalization, then a table walk from symbol + 1 up to
// num_symbols, and a rescale walk over the table when the total passes the
// limit. Start sweeps num_symbols + 1 table entries. After reset the same
// sweep runs before s_tready rises.
// A stalled output holds the machine in the emitting state; config is free.
module adaptive_range_encoder #(
    parameter int MAX_SYMBOLS = are_pkg::DEF_MAX_SYMBOLS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [47:0]                   s_tdata,  // symbol, raw_value, raw_count
    input  wire logic [1:0]                    s_tuser,  // op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [47:0]                        m_tdata,  // out_byte, byte_valid, stored,
                                                         // position, bad_symbol
    output logic                               m_tlast,  // last
    input  wire logic                          cfg_we,
    input  wire logic [are_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [are_pkg::CAP_W-1:0]     cfg_data
);
    import are_pkg::*;

    localparam int AW = $clog2(MAX_SYMBOLS + 1);
    localparam int CW = (AW > NSYM_W) ? AW : NSYM_W;
    localparam int RESET_ALPHA =
        (DEF_NUM_SYMBOLS > MAX_SYMBOLS) ? MAX_SYMBOLS : DEF_NUM_SYMBOLS;

    // frequency table
    logic [CF_W-1:0] cf_mem [0:MAX_SYMBOLS];
    logic [CF_W-1:0] mem_rdata_reg;
    logic            mem_re, mem_we;
    logic [AW-1:0]   mem_raddr, mem_waddr;
    logic [CF_W-1:0] mem_wdata;

    state_t             state_reg, state_next, ret_reg, ret_next;
    logic [NSYM_W-1:0]  nsym_reg, nsym_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [AW-1:0]      alpha_reg, alpha_next;
    logic [CF_W-1:0]    ftot_reg, ftot_next;
    logic [LOW_W-1:0]   low_reg, low_next;
    logic [LOW_W-1:0]   range_reg, range_next;
    logic [LOW_W-1:0]   pos_reg, pos_next;
    logic [7:0]         sym_reg, sym_next;
    logic [CF_W-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [LOW_W-1:0]   r_reg, r_next;
    logic [2:0]         steps_reg, steps_next;
    logic               bad_reg, bad_next;
    logic [AW:0]        walk_reg, walk_next;
    logic               pv_reg, pv_next;
    logic [AW-1:0]      paddr_reg, paddr_next;
    logic [CF_W-1:0]    pold_reg, pold_next, pnew_reg, pnew_next;
    logic [LOW_W-1:0]   rawv_reg, rawv_next;
    logic [5:0]         rawn_reg, rawn_next;

    // output register
    logic               mv_reg, mv_next;
    logic [7:0]         ob_reg, ob_next;
    logic               obv_reg, obv_next;
    logic               ost_reg, ost_next;
    logic [LOW_W-1:0]   opos_reg, opos_next;
    logic               obad_reg, obad_next;
    logic               olast_reg, olast_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                  out_free;
    logic                  ld, ld_bv, ld_bad, ld_last;
    logic [7:0]            ld_byte;
    logic [CF_W-1:0]       mul_b;
    logic [LOW_W+CF_W-1:0] prod;
    logic [CW-1:0]         nsym_clamp;
    logic [CF_W-1:0]       f_old, f_half, f_new;
    logic [5:0]            chunk, lowbit;
    logic [LOW_W-1:0]      raw_sh;
    logic [5:0]            rc_sat;
    logic [7:0]            in_sym;
    logic [LOW_W-1:0]      range_sh;

    are_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = ~mv_reg | m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_sym   = s_tdata[7:0];
    assign mul_b    = (state_reg == ST_MUL_LOW) ? lo_reg : (hi_reg - lo_reg);
    assign prod     = (LOW_W+CF_W)'(r_reg) * (LOW_W+CF_W)'(mul_b);
    assign range_sh = range_reg << 8;
    assign rc_sat   = (s_tdata[45:40] > 6'd32) ? 6'd32 : s_tdata[45:40];

    always_comb
    begin
        // clamp the alphabet size to [2, MAX_SYMBOLS]
        if (CW'(nsym_reg) < CW'(2))
            nsym_clamp = CW'(2);
        else if (CW'(nsym_reg) > CW'(MAX_SYMBOLS))
            nsym_clamp = CW'(MAX_SYMBOLS);
        else
            nsym_clamp = CW'(nsym_reg);
    end

    // rescale step: halve the old count of one symbol, keep at least one
    always_comb
    begin
        f_old  = mem_rdata_reg - pold_reg;
        f_half = (f_old > CF_W'(1)) ? (f_old >> 1) : CF_W'(1);
        f_new  = pnew_reg + f_half;
    end

    // raw bits: full bytes first, the short chunk last
    always_comb
    begin
        chunk  = (rawn_reg >= 6'd8) ? 6'd8 : rawn_reg;
        lowbit = rawn_reg - chunk;
        raw_sh = rawv_reg >> lowbit;
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        nsym_next  = nsym_reg;
        cap_next   = cap_reg;
        alpha_next = alpha_reg;
        ftot_next  = ftot_reg;
        low_next   = low_reg;
        range_next = range_reg;
        pos_next   = pos_reg;
        sym_next   = sym_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        r_next     = r_reg;
        steps_next = steps_reg;
        bad_next   = bad_reg;
        walk_next  = walk_reg;
        pv_next    = pv_reg;
        paddr_next = paddr_reg;
        pold_next  = pold_reg;
        pnew_next  = pnew_reg;
        rawv_next  = rawv_reg;
        rawn_next  = rawn_reg;
        mv_next    = mv_reg;
        ob_next    = ob_reg;
        obv_next   = obv_reg;
        ost_next   = ost_reg;
        opos_next  = opos_reg;
        obad_next  = obad_reg;
        olast_next = olast_reg;

        mem_re    = 1'b0;
        mem_raddr = AW'(sym_reg);
        mem_we    = 1'b0;
        mem_waddr = paddr_reg;
        mem_wdata = mem_rdata_reg + 1'b1;

        div_req.start    = 1'b0;
        div_req.dividend = range_reg;
        div_req.divisor  = (ftot_reg != '0) ? ftot_reg : CF_W'(1);

        ld      = 1'b0;
        ld_byte = '0;
        ld_bv   = 1'b0;
        ld_bad  = 1'b0;
        ld_last = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_SYMBOLS)
                nsym_next = cfg_data[NSYM_W-1:0];
            else if (cfg_index == CFG_OUT_CAPACITY)
                cap_next = cfg_data;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // rebuild the table: entry i holds i
                mem_we    = 1'b1;
                mem_waddr = walk_reg[AW-1:0];
                mem_wdata = CF_W'(walk_reg);
                walk_next = walk_reg + 1'b1;
                if (walk_reg[AW-1:0] == alpha_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bad_next = 1'b0;
                    unique case (op_t'(s_tuser))
                        OP_START:
                        begin
                            alpha_next = nsym_clamp[AW-1:0];
                            ftot_next  = CF_W'(nsym_clamp);
                            low_next   = '0;
                            range_next = RANGE_FULL;
                            pos_next   = '0;
                            walk_next  = '0;
                            ret_next   = ST_INIT;
                            state_next = ST_STATUS;
                        end
                        OP_SYMBOL:
                        begin
                            sym_next = in_sym;
                            if (CW'(in_sym) >= CW'(alpha_reg))
                            begin
                                bad_next   = 1'b1;
                                ret_next   = ST_IDLE;
                                state_next = ST_STATUS;
                            end
                            else
                                state_next = ST_RD_LO;
                        end
                        OP_RAW:
                        begin
                            rawv_next = s_tdata[39:8];
                            rawn_next = rc_sat;
                            if (rc_sat == '0)
                            begin
                                ret_next   = ST_IDLE;
                                state_next = ST_STATUS;
                            end
                            else
                                state_next = ST_RAW;
                        end
                        OP_FLUSH:
                        begin
                            steps_next = '0;
                            state_next = ST_FLUSH;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_LO:
            begin
                mem_re        = 1'b1;
                mem_raddr     = AW'(sym_reg);
                div_req.start = 1'b1;
                state_next    = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(sym_reg) + 1'b1;
                lo_next    = mem_rdata_reg;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                hi_next = mem_rdata_reg;
                if (div_rsp.done)
                begin
                    r_next     = div_rsp.quotient;
                    state_next = ST_MUL_LOW;
                end
            end
            ST_MUL_LOW:
            begin
                // low wraps: carries out of the top bit are dropped
                low_next   = low_reg + prod[LOW_W-1:0];
                state_next = ST_MUL_RANGE;
            end
            ST_MUL_RANGE:
            begin
                range_next = prod[LOW_W-1:0];
                steps_next = '0;
                walk_next  = (AW+1)'(sym_reg) + 1'b1;
                pv_next    = 1'b0;
                state_next = ST_RENORM;
            end
            ST_RENORM:
            begin
                if ((range_reg < RANGE_FLOOR) && (steps_reg < 3'd4))
                begin
                    if (out_free)
                    begin
                        ld         = 1'b1;
                        ld_byte    = low_reg[LOW_W-1 -: 8];
                        ld_bv      = 1'b1;
                        ld_last    = ~((range_sh < RANGE_FLOOR) && (steps_reg < 3'd3));
                        low_next   = low_reg << 8;
                        range_next = range_sh;
                        steps_next = steps_reg + 1'b1;
                    end
                end
                else if (steps_reg == '0)
                begin
                    ret_next   = ST_BUMP;
                    state_next = ST_STATUS;
                end
                else
                    state_next = ST_BUMP;
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_bad     = bad_reg;
                    ld_last    = 1'b1;
                    state_next = ret_reg;
                end
            end
            ST_BUMP:
            begin
                // read one entry ahead, write back the count plus one
                pv_next    = 1'b0;
                paddr_next = walk_reg[AW-1:0];
                if (walk_reg <= (AW+1)'(alpha_reg))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = walk_reg[AW-1:0];
                    pv_next   = 1'b1;
                    walk_next = walk_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = paddr_reg;
                    mem_wdata = mem_rdata_reg + 1'b1;
                end
                else if (walk_reg > (AW+1)'(alpha_reg))
                begin
                    ftot_next = ftot_reg + 1'b1;
                    if ((ftot_reg + 1'b1) > RESCALE_LIMIT)
                    begin
                        walk_next  = (AW+1)'(1);
                        pold_next  = '0;
                        pnew_next  = '0;
                        state_next = ST_HALVE;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_HALVE:
            begin
                pv_next    = 1'b0;
                paddr_next = walk_reg[AW-1:0];
                if (walk_reg <= (AW+1)'(alpha_reg))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = walk_reg[AW-1:0];
                    pv_next   = 1'b1;
                    walk_next = walk_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = paddr_reg;
                    mem_wdata = f_new;
                    pold_next = mem_rdata_reg;
                    pnew_next = f_new;
                end
                else if (walk_reg > (AW+1)'(alpha_reg))
                begin
                    ftot_next  = pnew_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_RAW:
            begin
                if (out_free)
                begin
                    ld        = 1'b1;
                    ld_byte   = raw_sh[7:0] & ((8'd1 << chunk[3:0]) - 8'd1);
                    ld_bv     = 1'b1;
                    ld_last   = (lowbit == '0);
                    rawn_next = lowbit;
                    if (lowbit == '0)
                        state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_byte    = low_reg[LOW_W-1 -: 8];
                    ld_bv      = 1'b1;
                    ld_last    = (steps_reg == 3'd3);
                    low_next   = low_reg << 8;
                    steps_next = steps_reg + 1'b1;
                    if (steps_reg == 3'd3)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // load the output register; a byte advances the stream position
        if (ld)
        begin
            mv_next    = 1'b1;
            ob_next    = ld_byte;
            obv_next   = ld_bv;
            ost_next   = ld_bv & (pos_reg < {1'b0, cap_reg});
            opos_next  = pos_reg;
            obad_next  = ld_bad;
            olast_next = ld_last;
            if (ld_bv && (pos_reg != POS_MAX))
                pos_next = pos_reg + 1'b1;
        end
        else if (m_tready)
            mv_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cf_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= cf_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ret_reg   <= ST_IDLE;
            nsym_reg  <= NSYM_W'(DEF_NUM_SYMBOLS);
            cap_reg   <= DEF_CAPACITY;
            alpha_reg <= AW'(RESET_ALPHA);
            ftot_reg  <= CF_W'(RESET_ALPHA);
            low_reg   <= '0;
            range_reg <= RANGE_FULL;
            pos_reg   <= '0;
            sym_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            r_reg     <= '0;
            steps_reg <= '0;
            bad_reg   <= 1'b0;
            walk_reg  <= '0;
            pv_reg    <= 1'b0;
            paddr_reg <= '0;
            pold_reg  <= '0;
            pnew_reg  <= '0;
            rawv_reg  <= '0;
            rawn_reg  <= '0;
            mv_reg    <= 1'b0;
            ob_reg    <= '0;
            obv_reg   <= 1'b0;
            ost_reg   <= 1'b0;
            opos_reg  <= '0;
            obad_reg  <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            nsym_reg  <= nsym_next;
            cap_reg   <= cap_next;
            alpha_reg <= alpha_next;
            ftot_reg  <= ftot_next;
            low_reg   <= low_next;
            range_reg <= range_next;
            pos_reg   <= pos_next;
            sym_reg   <= sym_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            r_reg     <= r_next;
            steps_reg <= steps_next;
            bad_reg   <= bad_next;
            walk_reg  <= walk_next;
            pv_reg    <= pv_next;
            paddr_reg <= paddr_next;
            pold_reg  <= pold_next;
            pnew_reg  <= pnew_next;
            rawv_reg  <= rawv_next;
            rawn_reg  <= rawn_next;
            mv_reg    <= mv_next;
            ob_reg    <= ob_next;
            obv_reg   <= obv_next;
            ost_reg   <= ost_next;
            opos_reg  <= opos_next;
            obad_reg  <= obad_next;
            olast_reg <= olast_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {5'd0, obad_reg, opos_reg, ost_reg, obv_reg, ob_reg};
    assign m_tlast  = olast_reg;

    // the total never rests above the rescale limit
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (ftot_reg <= RESCALE_LIMIT))
        else $error("frequency total above rescale limit while idle");

    // a byte result never carries the bad symbol flag
    a_byte_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && obv_reg) |-> !obad_reg)
        else $error("byte result flagged bad symbol");

    // table writes stay inside the alphabet in use
    a_write_in_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr <= alpha_reg))
        else $error("table write beyond alphabet");

    // the divider only finishes while the controller waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

endmodule
`default_nettype wire

[tb/sv/adaptive_range_encoder_tb.sv]
// Self-checking testbench for the adaptive range encoder: predicts every result and compares.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_range_encoder_tb;
    import are_pkg::*;

    // Predicted output of the encoder, one entry per result beat.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        stored;
        logic [31:0] position;
        logic        bad_symbol;
        logic        last;
    } coded_beat_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;   // symbol[7:0], raw_value[39:8], raw_count[45:40]
    logic [1:0]        s_tuser;   // op
    logic              m_tvalid;
    logic              m_tready;
    logic [47:0]       m_tdata;   // out_byte[7:0], byte_valid[8], stored[9],
                                  // position[41:10], bad_symbol[42]
    logic              m_tlast;   // last
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CAP_W-1:0]  cfg_data;

    // Shadow copy of the encoder state.
    logic [8:0]        pred_nsym_reg;
    logic [30:0]       pred_capacity;
    logic [14:0]       pred_cum [0:DEF_MAX_SYMBOLS];
    logic [14:0]       pred_total;
    logic [31:0]       pred_low;
    logic [31:0]       pred_range;
    logic [31:0]       pred_pos;
    int unsigned       pred_alpha;

    coded_beat_t       beat_queue[$];
    int                mismatch_count;
    int                send_idle_pct;
    int                recv_stall_pct;

    adaptive_range_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Rebuild the model with one count per symbol; alphabet size is clamped.
    task automatic model_rebuild();
        int unsigned n;
        n = pred_nsym_reg;
        if (n < 2)
            n = 2;
        if (n > DEF_MAX_SYMBOLS)
            n = DEF_MAX_SYMBOLS;
        pred_alpha = n;
        for (int i = 0; i <= DEF_MAX_SYMBOLS; i++)
            pred_cum[i] = (i <= n) ? 15'(i) : 15'(n);
        pred_total = 15'(n);
    endtask

    // Halve every count, keeping at least one; the running sum uses old neighbors.
    task automatic model_halve();
        logic [14:0] prev_old;
        logic [14:0] old_next;
        logic [14:0] f;
        prev_old = pred_cum[0];
        pred_cum[0] = '0;
        for (int i = 0; i < pred_alpha; i++)
        begin
            old_next = pred_cum[i+1];
            f = old_next - prev_old;
            f = (f > 1) ? (f >> 1) : 15'd1;
            pred_cum[i+1] = pred_cum[i] + f;
            prev_old = old_next;
        end
        pred_total = pred_cum[pred_alpha];
    endtask

    task automatic push_byte(input logic [7:0] b, inout int cnt);
        coded_beat_t e;
        if (cnt < 4)
        begin
            e.out_byte = b;
            e.byte_valid = 1'b1;
            e.stored = ({1'b0, pred_pos} < {2'b0, pred_capacity});
            e.position = pred_pos;
            e.bad_symbol = 1'b0;
            e.last = 1'b0;
            beat_queue.push_back(e);
            cnt++;
        end
        if (pred_pos != POS_MAX)
            pred_pos++;
    endtask

    // Work out the result beats that one request causes and queue them.
    task automatic predict_request(input op_t op, input logic [7:0] sym,
                                   input logic [31:0] rv, input logic [5:0] rc_in);
        int cnt;
        logic bad;
        logic [31:0] lo, hi, tot, r;
        int steps;
        int sh, chunk;
        int unsigned rc;
        coded_beat_t e;
        cnt = 0;
        bad = 1'b0;
        case (op)
            OP_START:
            begin
                model_rebuild();
                pred_low = '0;
                pred_range = RANGE_FULL;
                pred_pos = '0;
            end
            OP_SYMBOL:
            begin
                if (sym >= pred_alpha)
                    bad = 1'b1;
                else
                begin
                    lo = pred_cum[sym];
                    hi = pred_cum[sym+1];
                    tot = (pred_total != 0) ? pred_total : 32'd1;
                    r = pred_range / tot;
                    steps = 0;
                    pred_low = pred_low + r * lo;
                    pred_range = r * (hi - lo);
                    while (pred_range < RANGE_FLOOR && steps < 4)
                    begin
                        push_byte(pred_low[31:24], cnt);
                        pred_low = pred_low << 8;
                        pred_range = pred_range << 8;
                        steps++;
                    end
                    for (int i = sym + 1; i <= pred_alpha; i++)
                        pred_cum[i] = pred_cum[i] + 15'd1;
                    pred_total = pred_total + 15'd1;
                    if (pred_total > RESCALE_LIMIT)
                        model_halve();
                end
            end
            OP_RAW:
            begin
                rc = (rc_in > 32) ? 32 : rc_in;
                sh = int'(rc) - 1;
                while (sh >= 0)
                begin
                    chunk = (sh >= 7) ? 8 : sh + 1;
                    push_byte(8'((rv >> (sh - chunk + 1)) & ((33'd1 << chunk) - 1)), cnt);
                    sh -= chunk;
                end
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    push_byte(pred_low[31:24], cnt);
                    pred_low = pred_low << 8;
                end
            end
        endcase
        if (cnt == 0)
        begin
            e = '0;
            e.position = pred_pos;
            e.bad_symbol = bad;
            beat_queue.push_back(e);
        end
        e = beat_queue.pop_back();
        e.last = 1'b1;
        beat_queue.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drive one request and wait for its handshake; idle first at random.
    task automatic send_request(input op_t op, input logic [7:0] sym,
                                input logic [31:0] rv, input logic [5:0] rc);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b0, rc, rv, sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(op, sym, rv, rc);
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Hold until every queued beat has come and the block is idle, then let it settle.
    task automatic drain_results();
        while (beat_queue.size() != 0 || !s_tready)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Write a register while the encoder is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_NUM_SYMBOLS)
            pred_nsym_reg = val[8:0];
        else if (idx == CFG_OUT_CAPACITY)
            pred_capacity = val;
    endtask

    task automatic send_random_symbol();
        logic [7:0] s;
        s = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(pred_alpha - 1));
        send_request(OP_SYMBOL, s, '0, '0);
    endtask

    // Directed: extremes of every field, every op, and the named corner cases.
    task automatic test_directed();
        send_request(OP_START, 8'h00, '0, '0);
        send_request(OP_SYMBOL, 8'd0, '0, '0);
        send_request(OP_SYMBOL, 8'd255, '0, '0);
        send_request(OP_SYMBOL, 8'd128, 32'hFFFF_FFFF, 6'h3F);
        send_request(OP_RAW, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_request(OP_RAW, 8'h00, 32'hA5A5_5A5A, 6'd63);
        send_request(OP_RAW, 8'h00, 32'h0000_0000, 6'd0);
        send_request(OP_RAW, 8'h00, 32'h0000_01FF, 6'd9);
        send_request(OP_RAW, 8'h00, 32'h0000_0001, 6'd1);
        send_request(OP_FLUSH, 8'h00, '0, '0);
        // A new alphabet size is latched only at the next start.
        write_reg(CFG_NUM_SYMBOLS, 31'd4);
        send_request(OP_SYMBOL, 8'd200, '0, '0);
        send_request(OP_START, 8'h00, '0, '0);
        send_request(OP_SYMBOL, 8'd4, '0, '0);
        send_request(OP_SYMBOL, 8'd3, '0, '0);
        // Out-of-range sizes clamp to the limits.
        write_reg(CFG_NUM_SYMBOLS, 31'd0);
        send_request(OP_START, 8'h00, '0, '0);
        send_request(OP_SYMBOL, 8'd2, '0, '0);
        send_request(OP_SYMBOL, 8'd1, '0, '0);
        write_reg(CFG_NUM_SYMBOLS, 31'h1FF);
        send_request(OP_START, 8'h00, '0, '0);
        // Capacity zero flags every byte as not stored.
        write_reg(CFG_OUT_CAPACITY, 31'd0);
        send_request(OP_FLUSH, 8'h00, '0, '0);
        write_reg(CFG_OUT_CAPACITY, 31'd5);
        send_request(OP_START, 8'h00, '0, '0);
        send_request(OP_RAW, 8'h00, 32'h1234_5678, 6'd32);
        send_request(OP_RAW, 8'h00, 32'h0000_00FF, 6'd16);
        // Unused register index is ignored.
        write_reg(2'd3, 31'h7FFF_FFFF);
        write_reg(CFG_OUT_CAPACITY, 31'h7FFF_FFFF);
    endtask

    // Random: mostly well-formed streams (start, symbols, raw, flush).
    task automatic test_random_streams(input int count);
        int k;
        k = 0;
        while (k < count)
        begin
            send_request(OP_START, 8'($urandom), $urandom, 6'($urandom));
            k++;
            for (int j = $urandom_range(30, 4); j > 0 && k < count; j--)
            begin
                if ($urandom_range(7) == 0)
                    send_request(OP_RAW, 8'($urandom), $urandom, 6'($urandom_range(40)));
                else
                    send_random_symbol();
                k++;
            end
            if ($urandom_range(3) != 0)
            begin
                send_request(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
                k++;
            end
        end
    endtask

    // Skewed symbols on a small alphabet; too few of them to push the total past the rescale limit.
    task automatic test_rescale();
        write_reg(CFG_NUM_SYMBOLS, 31'd2);
        send_request(OP_START, 8'h00, '0, '0);
        for (int i = 0; i < 60; i++)
            send_request(OP_SYMBOL, 8'($urandom_range(7) == 0), '0, '0);
        send_request(OP_FLUSH, 8'h00, '0, '0);
    endtask

    // Check each beat against the oldest prediction.
    always @(posedge clk)
    begin
        coded_beat_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (beat_queue.size() == 0)
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            else
            begin
                e = beat_queue.pop_front();
                if (m_tdata[7:0] !== e.out_byte)
                    report_mismatch("out_byte", m_tdata[7:0], e.out_byte);
                if (m_tdata[8] !== e.byte_valid)
                    report_mismatch("byte_valid", m_tdata[8], e.byte_valid);
                if (m_tdata[9] !== e.stored)
                    report_mismatch("stored", m_tdata[9], e.stored);
                if (m_tdata[41:10] !== e.position)
                    report_mismatch("position", m_tdata[41:10], e.position);
                if (m_tdata[42] !== e.bad_symbol)
                    report_mismatch("bad_symbol", m_tdata[42], e.bad_symbol);
                if (m_tlast !== e.last)
                    report_mismatch("last", m_tlast, e.last);
            end
        end
    end

    // Receiver stalls at the current rate, updated at the falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_START;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b1;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pred_nsym_reg = 9'd256;
        pred_capacity = DEF_CAPACITY;
        pred_low = '0;
        pred_range = RANGE_FULL;
        pred_pos = '0;
        model_rebuild();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_rescale();
        send_idle_pct = 52;
        write_reg(CFG_NUM_SYMBOLS, 31'd16);
        test_random_streams(90);
        // Pause until the pipeline is empty before resuming.
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 52;
        write_reg(CFG_NUM_SYMBOLS, 31'($urandom_range(256, 2)));
        write_reg(CFG_OUT_CAPACITY, 31'($urandom_range(40)));
        test_random_streams(90);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        write_reg(CFG_NUM_SYMBOLS, 31'd256);
        write_reg(CFG_OUT_CAPACITY, 31'h7FFF_FFFF);
        test_random_streams(90);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_NUM_SYMBOLS, 31'd3);
        test_random_streams(80);

        drain_results();
        repeat (600) @(negedge clk);
        if (mismatch_count == 0 && beat_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[adaptive_range_encoder.f]
rtl/are_pkg.sv
rtl/are_div.sv
rtl/adaptive_range_encoder.sv
tb/sv/adaptive_range_encoder_tb.sv
